// ===== rtl/dcpid_pkg.sv =====
// dcpid_pkg: shared widths, register indexes and control types of the
// dual channel pid speed controller; used by every module under rtl

package dcpid_pkg;

    // fixed point format of the gains
    localparam int GAIN_FRAC_BITS = 6;

    // field and datapath widths
    localparam int GAIN_W  = 16;
    localparam int DATA_W  = 16;
    localparam int LIM_W   = 15;
    localparam int ERR_W   = DATA_W + 1;
    localparam int PROD_W  = GAIN_W + ERR_W + 1;
    localparam int ACC_W   = PROD_W + 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KP_A      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_B      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KI_A      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI_B      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD_A      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KD_B      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd6;

    // register reset values
    localparam logic [GAIN_W-1:0] KP_RESET    = 16'd6400;
    localparam logic [GAIN_W-1:0] KI_RESET    = 16'd0;
    localparam logic [GAIN_W-1:0] KD_RESET    = 16'd64;
    localparam logic [LIM_W-1:0]  LIMIT_RESET = 15'd7000;

    // gains of one channel
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    // pipeline load strobes shared by both lanes
    typedef struct packed {
        logic load_in;
        logic load_mul;
    } lane_ctrl_t;

endpackage

// ===== rtl/dcpid_lane.sv =====
// dcpid_lane: one pid channel: error and integral stage, multiply stage,
// then sum, scaling and output clamp; depends on dcpid_pkg

module dcpid_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dcpid_pkg::lane_ctrl_t               ctrl,
    input  dcpid_pkg::gains_t                   gains,
    input  logic [dcpid_pkg::LIM_W-1:0]         limit,
    input  logic signed [dcpid_pkg::DATA_W-1:0] setpoint,
    input  logic signed [dcpid_pkg::DATA_W-1:0] measured,
    output logic signed [dcpid_pkg::DATA_W-1:0] drive
);

    localparam int DW = dcpid_pkg::DATA_W;
    localparam int EW = dcpid_pkg::ERR_W;
    localparam int PW = dcpid_pkg::PROD_W;
    localparam int AW = dcpid_pkg::ACC_W;
    localparam int LW = dcpid_pkg::LIM_W;
    localparam int FB = dcpid_pkg::GAIN_FRAC_BITS;
    localparam int SW = DW + 2;
    localparam logic signed [AW-1:0] ROUND_BIAS = AW'((1 << FB) - 1);

    // loop state
    logic signed [DW-1:0] integral_reg, integral_next;
    logic signed [DW-1:0] prev_meas_reg;

    // stage one registers
    logic signed [EW-1:0] err_reg;
    logic signed [DW-1:0] integ_reg;
    logic signed [EW-1:0] dmeas_reg;

    // stage two registers
    logic signed [PW-1:0] p_term_reg, p_term_next;
    logic signed [PW-1:0] i_term_reg, i_term_next;
    logic signed [PW-1:0] d_term_reg, d_term_next;

    logic signed [EW-1:0] err;
    logic signed [EW-1:0] dmeas;
    logic signed [SW-1:0] isum;
    logic signed [SW-1:0] lim_s;
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] acc_biased;
    logic signed [AW-1:0] scaled;
    logic signed [AW-1:0] lim_a;

    // error, measurement step and clamped integral
    always_comb
    begin
        err   = $signed({setpoint[DW-1], setpoint}) - $signed({measured[DW-1], measured});
        dmeas = $signed({measured[DW-1], measured})
              - $signed({prev_meas_reg[DW-1], prev_meas_reg});
        isum  = $signed({{2{integral_reg[DW-1]}}, integral_reg}) + $signed({err[EW-1], err});
        lim_s = $signed({{(SW-LW){1'b0}}, limit});
        if (isum > lim_s)
        begin
            integral_next = lim_s[DW-1:0];
        end
        else if (isum < -lim_s)
        begin
            integral_next = DW'(-lim_s);
        end
        else
        begin
            integral_next = isum[DW-1:0];
        end
    end

    // loop state, updated on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            prev_meas_reg <= '0;
        end
        else if (ctrl.load_in)
        begin
            integral_reg  <= integral_next;
            prev_meas_reg <= measured;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            err_reg   <= err;
            integ_reg <= integral_next;
            dmeas_reg <= dmeas;
        end
    end

    // three gain products side by side
    always_comb
    begin
        p_term_next = PW'($signed({1'b0, gains.kp}) * err_reg);
        i_term_next = PW'($signed({1'b0, gains.ki}) * integ_reg);
        d_term_next = PW'($signed({1'b0, gains.kd}) * dmeas_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_mul)
        begin
            p_term_reg <= p_term_next;
            i_term_reg <= i_term_next;
            d_term_reg <= d_term_next;
        end
    end

    // sum, scale with truncation toward zero, clamp to the limit
    always_comb
    begin
        acc = $signed({{(AW-PW){p_term_reg[PW-1]}}, p_term_reg})
            + $signed({{(AW-PW){i_term_reg[PW-1]}}, i_term_reg})
            - $signed({{(AW-PW){d_term_reg[PW-1]}}, d_term_reg});
        acc_biased = acc[AW-1] ? (acc + ROUND_BIAS) : acc;
        scaled     = acc_biased >>> FB;
        lim_a      = $signed({{(AW-LW){1'b0}}, limit});
        if (scaled > lim_a)
        begin
            drive = lim_a[DW-1:0];
        end
        else if (scaled < -lim_a)
        begin
            drive = DW'(-lim_a);
        end
        else
        begin
            drive = scaled[DW-1:0];
        end
    end

endmodule

// ===== rtl/dcpid_merge.sv =====
// dcpid_merge: joins the two lane results into one registered drive
// request and holds it against stall; depends on dcpid_pkg

module dcpid_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                lanes_valid,
    input  logic signed [dcpid_pkg::DATA_W-1:0] lane_drive_a,
    input  logic signed [dcpid_pkg::DATA_W-1:0] lane_drive_b,
    input  logic                                drive_stall,
    output logic                                advance,
    output logic                                drive_valid,
    output logic signed [dcpid_pkg::DATA_W-1:0] drive_a,
    output logic signed [dcpid_pkg::DATA_W-1:0] drive_b
);

    logic                                valid_reg;
    logic signed [dcpid_pkg::DATA_W-1:0] drive_a_reg;
    logic signed [dcpid_pkg::DATA_W-1:0] drive_b_reg;

    // output register is free when empty or being taken
    assign advance = !valid_reg || !drive_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= lanes_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance && lanes_valid)
        begin
            drive_a_reg <= lane_drive_a;
            drive_b_reg <= lane_drive_b;
        end
    end

    assign drive_valid = valid_reg;
    assign drive_a     = drive_a_reg;
    assign drive_b     = drive_b_reg;

endmodule

// ===== rtl/dual_channel_pid_speed_control.sv =====
// dual_channel_pid_speed_control: top level with configuration registers,
// pipeline control, two pid lanes and the merge stage
// depends on dcpid_pkg, dcpid_lane and dcpid_merge

// Two PID speed loops, one per motor, advance together on every accepted
// tick request. The block takes one request per clock cycle while
// tick_stall is low; results pass an error/integral stage, a multiply
// stage and the output register. The rate is set by the integral update,
// a single add and clamp that feeds itself from one request to the next.
// Stages refill while a finished result waits, so up to three requests
// are held inside. The user is to write gains and the limit through
// cfg_we/cfg_index/cfg_data only while the block is idle; the block does
// not enforce this. Writes to unknown indexes are ignored.

module dual_channel_pid_speed_control (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dcpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcpid_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 tick_valid,
    output logic                                 tick_stall,
    input  logic signed [dcpid_pkg::DATA_W-1:0]  setpoint_a,
    input  logic signed [dcpid_pkg::DATA_W-1:0]  measured_a,
    input  logic signed [dcpid_pkg::DATA_W-1:0]  setpoint_b,
    input  logic signed [dcpid_pkg::DATA_W-1:0]  measured_b,
    output logic                                 drive_valid,
    input  logic                                 drive_stall,
    output logic signed [dcpid_pkg::DATA_W-1:0]  drive_a,
    output logic signed [dcpid_pkg::DATA_W-1:0]  drive_b
);

    // configuration registers
    dcpid_pkg::gains_t                 gains_a_reg;
    dcpid_pkg::gains_t                 gains_b_reg;
    logic [dcpid_pkg::LIM_W-1:0]       limit_reg;

    // pipeline occupancy
    logic                              v1_reg;
    logic                              v2_reg;
    logic                              adv_out;
    logic                              adv2;
    logic                              adv1;
    logic                              accept;
    dcpid_pkg::lane_ctrl_t             ctrl;

    logic signed [dcpid_pkg::DATA_W-1:0] lane_drive_a;
    logic signed [dcpid_pkg::DATA_W-1:0] lane_drive_b;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_a_reg.kp <= dcpid_pkg::KP_RESET;
            gains_b_reg.kp <= dcpid_pkg::KP_RESET;
            gains_a_reg.ki <= dcpid_pkg::KI_RESET;
            gains_b_reg.ki <= dcpid_pkg::KI_RESET;
            gains_a_reg.kd <= dcpid_pkg::KD_RESET;
            gains_b_reg.kd <= dcpid_pkg::KD_RESET;
            limit_reg      <= dcpid_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dcpid_pkg::REG_KP_A:      gains_a_reg.kp <= cfg_data;
                dcpid_pkg::REG_KP_B:      gains_b_reg.kp <= cfg_data;
                dcpid_pkg::REG_KI_A:      gains_a_reg.ki <= cfg_data;
                dcpid_pkg::REG_KI_B:      gains_b_reg.ki <= cfg_data;
                dcpid_pkg::REG_KD_A:      gains_a_reg.kd <= cfg_data;
                dcpid_pkg::REG_KD_B:      gains_b_reg.kd <= cfg_data;
                dcpid_pkg::REG_OUT_LIMIT: limit_reg <= cfg_data[dcpid_pkg::LIM_W-1:0];
                default:                  ;
            endcase
        end
    end

    // stage advance chain, from the output back to the request side
    assign adv2       = !v2_reg || adv_out;
    assign adv1       = !v1_reg || adv2;
    assign accept     = tick_valid && adv1;
    assign tick_stall = !adv1;

    assign ctrl.load_in  = accept;
    assign ctrl.load_mul = adv2 && v1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= accept;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // channel lanes
    dcpid_lane u_lane_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .gains    (gains_a_reg),
        .limit    (limit_reg),
        .setpoint (setpoint_a),
        .measured (measured_a),
        .drive    (lane_drive_a)
    );

    dcpid_lane u_lane_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .gains    (gains_b_reg),
        .limit    (limit_reg),
        .setpoint (setpoint_b),
        .measured (measured_b),
        .drive    (lane_drive_b)
    );

    // merged output register
    dcpid_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .lanes_valid  (v2_reg),
        .lane_drive_a (lane_drive_a),
        .lane_drive_b (lane_drive_b),
        .drive_stall  (drive_stall),
        .advance      (adv_out),
        .drive_valid  (drive_valid),
        .drive_a      (drive_a),
        .drive_b      (drive_b)
    );

endmodule

// ===== tb/sv/tb_dual_channel_pid_speed_control.sv =====
// tb_dual_channel_pid_speed_control: self-checking bench for the dual channel pid speed loops,
// with directed and random ticks under random idle and stall, against an in-bench loop predictor
// depends on dcpid_pkg and dual_channel_pid_speed_control

module tb_dual_channel_pid_speed_control;

    import dcpid_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 23;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] sp_a;
        logic signed [DATA_W-1:0] meas_a;
        logic signed [DATA_W-1:0] sp_b;
        logic signed [DATA_W-1:0] meas_b;
    } tick_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive_a;
        logic signed [DATA_W-1:0] drive_b;
    } drive_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     tick_valid = 1'b0;
    logic                     tick_stall;
    logic signed [DATA_W-1:0] setpoint_a = '0;
    logic signed [DATA_W-1:0] measured_a = '0;
    logic signed [DATA_W-1:0] setpoint_b = '0;
    logic signed [DATA_W-1:0] measured_b = '0;
    logic                     drive_valid;
    logic                     drive_stall = 1'b0;
    logic signed [DATA_W-1:0] drive_a;
    logic signed [DATA_W-1:0] drive_b;

    // predicted loop state and settings
    gains_t                   lane_gains [2];
    logic signed [DATA_W-1:0] lane_integ [2];
    logic signed [DATA_W-1:0] lane_prev [2];
    logic [LIM_W-1:0]         drive_limit;
    logic signed [DATA_W-1:0] speed_target [2];

    drive_t pending_drives [$];
    int     mismatches = 0;
    int     cycle_count = 0;
    logic   no_idle = 1'b0;

    dual_channel_pid_speed_control u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .setpoint_a  (setpoint_a),
        .measured_a  (measured_a),
        .setpoint_b  (setpoint_b),
        .measured_b  (measured_b),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive_a     (drive_a),
        .drive_b     (drive_b)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // random backpressure on the drive side
    always @(posedge clk)
    begin
        drive_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // compare each drive result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && drive_valid && !drive_stall)
        begin
            if (pending_drives.size() == 0)
            begin
                report_mismatch($sformatf("drive result with none pending: a=%0d b=%0d",
                                          drive_a, drive_b));
            end
            else
            begin
                if (drive_a !== pending_drives[0].drive_a)
                    report_mismatch($sformatf("drive_a got %0d want %0d",
                                              drive_a, pending_drives[0].drive_a));
                if (drive_b !== pending_drives[0].drive_b)
                    report_mismatch($sformatf("drive_b got %0d want %0d",
                                              drive_b, pending_drives[0].drive_b));
                void'(pending_drives.pop_front());
            end
        end
    end

    function automatic longint clamp_sym(input longint x, input longint lim);
        if (x > lim)
            return lim;
        if (x < -lim)
            return -lim;
        return x;
    endfunction

    // one pid loop step: integral clamp, derivative on measurement, truncating scale
    function automatic logic signed [DATA_W-1:0] loop_drive(input int ch,
                                                            input logic signed [DATA_W-1:0] sp,
                                                            input logic signed [DATA_W-1:0] meas);
        longint lim;
        longint err;
        longint integ;
        longint acc;
        lim = longint'(drive_limit);
        err = longint'(sp) - longint'(meas);
        integ = clamp_sym(longint'(lane_integ[ch]) + err, lim);
        lane_integ[ch] = integ[DATA_W-1:0];
        acc = longint'(lane_gains[ch].kp) * err + longint'(lane_gains[ch].ki) * integ
            - longint'(lane_gains[ch].kd) * (longint'(meas) - longint'(lane_prev[ch]));
        acc = acc / (longint'(1) << GAIN_FRAC_BITS);
        lane_prev[ch] = meas;
        acc = clamp_sym(acc, lim);
        return acc[DATA_W-1:0];
    endfunction

    function automatic drive_t advance_loops(input tick_t t);
        drive_t d;
        d.drive_a = loop_drive(0, t.sp_a, t.meas_a);
        d.drive_b = loop_drive(1, t.sp_b, t.meas_b);
        return d;
    endfunction

    task automatic reset_loops();
        for (int ch = 0; ch < 2; ch++)
        begin
            lane_gains[ch].kp = KP_RESET;
            lane_gains[ch].ki = KI_RESET;
            lane_gains[ch].kd = KD_RESET;
            lane_integ[ch] = '0;
            lane_prev[ch] = '0;
            speed_target[ch] = '0;
        end
        drive_limit = LIMIT_RESET;
    endtask

    // register write, mirrored into the predicted settings
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_KP_A:      lane_gains[0].kp = data;
            REG_KP_B:      lane_gains[1].kp = data;
            REG_KI_A:      lane_gains[0].ki = data;
            REG_KI_B:      lane_gains[1].ki = data;
            REG_KD_A:      lane_gains[0].kd = data;
            REG_KD_B:      lane_gains[1].kd = data;
            REG_OUT_LIMIT: drive_limit = data[LIM_W-1:0];
            default:       ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] kp_a, input logic [CFG_DATA_W-1:0] kp_b,
                                 input logic [CFG_DATA_W-1:0] ki_a, input logic [CFG_DATA_W-1:0] ki_b,
                                 input logic [CFG_DATA_W-1:0] kd_a, input logic [CFG_DATA_W-1:0] kd_b,
                                 input logic [CFG_DATA_W-1:0] limit);
        write_reg(REG_KP_A, kp_a);
        write_reg(REG_KP_B, kp_b);
        write_reg(REG_KI_A, ki_a);
        write_reg(REG_KI_B, ki_b);
        write_reg(REG_KD_A, kd_a);
        write_reg(REG_KD_B, kd_b);
        write_reg(REG_OUT_LIMIT, limit);
    endtask

    function automatic tick_t tick_of(input int sp_a, input int meas_a,
                                      input int sp_b, input int meas_b);
        tick_t t;
        t.sp_a = DATA_W'(sp_a);
        t.meas_a = DATA_W'(meas_a);
        t.sp_b = DATA_W'(sp_b);
        t.meas_b = DATA_W'(meas_b);
        return t;
    endfunction

    // send one tick request, with random idle cycles ahead of it
    task automatic send_tick(input tick_t t);
        while (!no_idle && ($urandom_range(99) < IDLE_PERCENT))
        begin
            tick_valid <= 1'b0;
            @(posedge clk);
        end
        tick_valid <= 1'b1;
        setpoint_a <= t.sp_a;
        measured_a <= t.meas_a;
        setpoint_b <= t.sp_b;
        measured_b <= t.meas_b;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        pending_drives.push_back(advance_loops(t));
    endtask

    // stop sending and let every pending drive come out
    task automatic wait_idle();
        tick_valid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_defaults();
        send_tick(tick_of(0, 0, 0, 0));
        send_tick(tick_of(100, 90, -100, -90));
        send_tick(tick_of(32767, -32768, -32768, 32767));
        wait_idle();
    endtask

    // all registers at their top value, limit written with its unused bit set
    task automatic test_register_extremes();
        write_reg(REG_NONE, 16'h0000);
        send_tick(tick_of(20, 0, -20, 0));
        wait_idle();
        load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(REG_NONE, 16'h1234);
        send_tick(tick_of(32767, -32768, -32768, 32767));
        send_tick(tick_of(-32768, 32767, 32767, -32768));
        send_tick(tick_of(0, 0, 0, 0));
        wait_idle();
    endtask

    // negative accumulators must truncate toward zero
    task automatic test_truncation();
        load_settings(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd32767);
        send_tick(tick_of(0, 63, 0, -63));
        send_tick(tick_of(0, 64, 0, -64));
        send_tick(tick_of(0, 65, 0, -65));
        send_tick(tick_of(-32768, 32767, 32767, -32768));
        wait_idle();
    endtask

    // integral runs into the clamp from both sides
    task automatic test_integral_clamp();
        load_settings(16'd0, 16'd0, 16'd64, 16'd64, 16'd0, 16'd0, 16'd50);
        send_tick(tick_of(30, 0, -30, 0));
        send_tick(tick_of(30, 0, -30, 0));
        send_tick(tick_of(-200, 0, 200, 0));
        send_tick(tick_of(0, 0, 0, 0));
        wait_idle();
    endtask

    // zero limit holds drives at zero while the last measurement still moves
    task automatic test_zero_limit();
        load_settings(16'd6400, 16'd6400, 16'd64, 16'd64, 16'd64, 16'd64, 16'd0);
        send_tick(tick_of(1000, -1000, -1000, 1000));
        send_tick(tick_of(5, 7, -300, 20));
        wait_idle();
        write_reg(REG_OUT_LIMIT, 16'd7000);
        send_tick(tick_of(0, 100, 0, -100));
        wait_idle();
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_gain();
        if ($urandom_range(3) == 0)
            return CFG_DATA_W'($urandom());
        return CFG_DATA_W'($urandom_range(512));
    endfunction

    function automatic logic signed [DATA_W-1:0] near_speed(input logic signed [DATA_W-1:0] s);
        longint v;
        v = longint'(s) + longint'($urandom_range(400)) - 200;
        v = (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
        return v[DATA_W-1:0];
    endfunction

    // mostly a measurement that follows a slowly moving target, the rest noise
    task automatic make_random_tick(output tick_t t);
        if ($urandom_range(99) < 70)
        begin
            for (int ch = 0; ch < 2; ch++)
            begin
                if ($urandom_range(15) == 0)
                    speed_target[ch] = ($urandom_range(3) == 0) ? DATA_W'($urandom())
                                                                : DATA_W'(int'($urandom_range(8000)) - 4000);
            end
            t.sp_a = speed_target[0];
            t.meas_a = near_speed(speed_target[0]);
            t.sp_b = speed_target[1];
            t.meas_b = near_speed(speed_target[1]);
        end
        else
        begin
            t = tick_t'({$urandom(), $urandom()});
        end
    endtask

    task automatic test_random_loops();
        tick_t t;
        logic [CFG_DATA_W-1:0] limit;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            limit = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom())
                                             : CFG_DATA_W'($urandom_range(8000));
            case (phase)
                0: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'h7FFF);
                1: load_settings(random_gain(), random_gain(), random_gain(), random_gain(),
                                 random_gain(), random_gain(), 16'd0);
                2: load_settings(random_gain(), random_gain(), random_gain(), random_gain(),
                                 random_gain(), random_gain(), 16'd1);
                3: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, limit);
                default: load_settings(random_gain(), random_gain(), random_gain(), random_gain(),
                                       random_gain(), random_gain(), limit);
            endcase
            write_reg(REG_NONE, CFG_DATA_W'($urandom()));
            // one phase runs back to back with no idling on either side
            no_idle = (phase == 4);
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                make_random_tick(t);
                send_tick(t);
            end
            wait_idle();
            no_idle = 1'b0;
        end
    endtask

    // test sequence
    initial
    begin
        reset_loops();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_register_extremes();
        test_truncation();
        test_integral_clamp();
        test_zero_limit();
        test_random_loops();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
